FILE: sv/bsce_pkg.sv
// bsce_pkg: shared widths, register indexes and curve coefficient constants
// for the bezier speed curve evaluator; no dependencies
package bsce_pkg;

    localparam int unsigned RATE_W  = 20;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ACC_W   = 64;
    localparam int unsigned OUT_W   = 26;
    localparam int unsigned ADDR_W  = 2;

    // output is the upper accumulator word shifted right by six
    localparam int unsigned OUT_SHIFT = 6;
    localparam int unsigned OUT_LSB   = WORD_W + OUT_SHIFT;
    // constant term F is placed at bit 31 of the accumulator
    localparam int unsigned F_SHIFT   = 31;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] CFG_START_RATE = 2'd0;
    localparam logic [ADDR_W-1:0] CFG_END_RATE   = 2'd1;
    localparam logic [ADDR_W-1:0] CFG_TIME_SCALE = 2'd2;

    // polynomial coefficient multipliers
    localparam logic [WORD_W-1:0] COEF_A = 32'd768;
    localparam logic [WORD_W-1:0] COEF_B = 32'd1920;
    localparam logic [WORD_W-1:0] COEF_C = 32'd1280;
    localparam logic [WORD_W-1:0] COEF_F = 32'd128;

    localparam int unsigned PIPE_DEPTH = 7;

endpackage

FILE: sv/bsce_ifs.sv
// bsce channel interfaces: step position input, step rate output and
// configuration write channel; depends on bsce_pkg
interface bsce_step_if;
    logic                         valid;
    logic                         ready;
    logic [bsce_pkg::WORD_W-1:0]  step_position;

    modport source (output valid, output step_position, input ready);
    modport sink   (input valid, input step_position, output ready);
endinterface

interface bsce_rate_if;
    logic                         valid;
    logic                         ready;
    logic [bsce_pkg::OUT_W-1:0]   step_rate;

    modport source (output valid, output step_rate, input ready);
    modport sink   (input valid, input step_rate, output ready);
endinterface

interface bsce_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bsce_pkg::ADDR_W-1:0]  addr;
    logic [bsce_pkg::WORD_W-1:0]  data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: sv/bezier_speed_curve_eval.sv
// bezier_speed_curve_eval: quintic bezier s-curve step rate evaluator
// depends on bsce_pkg and the channel interfaces in bsce_ifs.sv
// an accepted step position word passes through stages 0 to 6 before its rate word is offered
// throughput: one word per cycle while the rate receiver is ready, through the seven-stage multiply chain
// reset (synchronous, active low) clears all stage valid bits and the
// three configuration registers to zero
module bezier_speed_curve_eval (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bsce_cfg_if.sink     i_cfg,
    bsce_step_if.sink    i_step,
    bsce_rate_if.source  o_rate
);

    localparam int unsigned D = bsce_pkg::PIPE_DEPTH;

    // configuration registers
    logic [bsce_pkg::RATE_W-1:0] r_start_rate;
    logic [bsce_pkg::RATE_W-1:0] r_end_rate;
    logic [bsce_pkg::WORD_W-1:0] r_time_scale;

    // coefficients; the user, not the block, keeps them static in flight
    logic [bsce_pkg::WORD_W-1:0] w_diff;
    logic [bsce_pkg::WORD_W-1:0] w_ca;
    logic [bsce_pkg::WORD_W-1:0] w_cb;
    logic [bsce_pkg::WORD_W-1:0] w_cc;
    logic [bsce_pkg::WORD_W-1:0] w_cf;

    // registered copies of w_ca, w_cb, w_cc and w_cf; the first
    // use is three stages after a word is taken
    logic [bsce_pkg::WORD_W-1:0] r_ca;
    logic [bsce_pkg::WORD_W-1:0] r_cb;
    logic [bsce_pkg::WORD_W-1:0] r_cc;
    logic [bsce_pkg::WORD_W-1:0] r_cf;

    // per-stage valid bits and load enables
    logic [D-1:0] r_v;
    logic [D-1:0] w_en;

    // stage payload registers
    logic [bsce_pkg::WORD_W-1:0] r_s0_t;
    logic [bsce_pkg::WORD_W-1:0] r_s1_t;
    logic [bsce_pkg::WORD_W-1:0] r_s1_f;
    logic [bsce_pkg::WORD_W-1:0] r_s2_t;
    logic [bsce_pkg::WORD_W-1:0] r_s2_f;
    logic [bsce_pkg::WORD_W-1:0] r_s3_t;
    logic [bsce_pkg::WORD_W-1:0] r_s3_f;
    logic [bsce_pkg::ACC_W-1:0]  r_s3_pc;
    logic [bsce_pkg::WORD_W-1:0] r_s4_f;
    logic [bsce_pkg::ACC_W-1:0]  r_s4_pb;
    logic [bsce_pkg::ACC_W-1:0]  r_s4_acc;
    logic [bsce_pkg::ACC_W-1:0]  r_s5_pa;
    logic [bsce_pkg::ACC_W-1:0]  r_s5_acc;
    logic [bsce_pkg::ACC_W-1:0]  r_s6_acc;

    // next values of the stage registers
    logic [bsce_pkg::WORD_W-1:0] n_t;
    logic [bsce_pkg::ACC_W-1:0]  n_sq;
    logic [bsce_pkg::ACC_W-1:0]  n_cube;
    logic [bsce_pkg::ACC_W-1:0]  n_quart;
    logic [bsce_pkg::ACC_W-1:0]  n_quint;
    logic signed [bsce_pkg::ACC_W-1:0] n_pc;
    logic signed [bsce_pkg::ACC_W-1:0] n_pb;
    logic signed [bsce_pkg::ACC_W-1:0] n_pa;
    logic [bsce_pkg::ACC_W-1:0]  n_acc_init;

    // ---------------------------------------------------------------
    // configuration port, always ready; unknown indexes are dropped
    // ---------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_rate <= '0;
            r_end_rate   <= '0;
            r_time_scale <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                bsce_pkg::CFG_START_RATE: r_start_rate <= i_cfg.data[bsce_pkg::RATE_W-1:0];
                bsce_pkg::CFG_END_RATE:   r_end_rate   <= i_cfg.data[bsce_pkg::RATE_W-1:0];
                bsce_pkg::CFG_TIME_SCALE: r_time_scale <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // coefficients wrap at 32 bits; B is the negation of 1920*(v1-v0)
    assign w_diff = {{(bsce_pkg::WORD_W-bsce_pkg::RATE_W){1'b0}}, r_end_rate}
                  - {{(bsce_pkg::WORD_W-bsce_pkg::RATE_W){1'b0}}, r_start_rate};
    assign w_ca   = w_diff * bsce_pkg::COEF_A;
    assign w_cb   = (~w_diff + 32'd1) * bsce_pkg::COEF_B;
    assign w_cc   = w_diff * bsce_pkg::COEF_C;
    assign w_cf   = {{(bsce_pkg::WORD_W-bsce_pkg::RATE_W){1'b0}}, r_start_rate}
                  * bsce_pkg::COEF_F;

    // keeps the coefficient arithmetic off the multiplier paths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca <= '0;
            r_cb <= '0;
            r_cc <= '0;
            r_cf <= '0;
        end else begin
            r_ca <= w_ca;
            r_cb <= w_cb;
            r_cc <= w_cc;
            r_cf <= w_cf;
        end
    end

    // ---------------------------------------------------------------
    // elastic pipeline control: a stage loads when empty or when the
    // stage after it moves, so bubbles are squeezed out under stall
    // ---------------------------------------------------------------
    always_comb begin
        w_en[D-1] = !r_v[D-1] || o_rate.ready;
        for (int k = D - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_step.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_step.valid;
            end
            for (int k = 1; k < D; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // datapath: at most one 32x32 multiply (plus one coefficient
    // multiply in parallel) and at most one 64-bit add per stage
    // ---------------------------------------------------------------
    // stage 0: curve parameter t, low word of scale*step
    assign n_t      = r_time_scale * i_step.step_position;
    // stage 1: t^2 high word
    assign n_sq     = 64'(r_s0_t) * 64'(r_s0_t);
    // stage 2: t^3 high word
    assign n_cube   = 64'(r_s1_f) * 64'(r_s1_t);
    // stage 3: t^4 and the C term from t^3
    assign n_quart  = 64'(r_s2_f) * 64'(r_s2_t);
    assign n_pc     = $signed({1'b0, r_s2_f[bsce_pkg::WORD_W-1:1]}) * $signed(r_cc);
    // stage 4: t^5, the B term, accumulator seeded with F<<31 plus C term
    assign n_quint  = 64'(r_s3_f) * 64'(r_s3_t);
    assign n_pb     = $signed({1'b0, r_s3_f[bsce_pkg::WORD_W-1:1]}) * $signed(r_cb);
    assign n_acc_init = {1'b0, r_cf, {bsce_pkg::F_SHIFT{1'b0}}};
    // stage 5: the A term from t^5
    assign n_pa     = $signed({1'b0, r_s4_f[bsce_pkg::WORD_W-1:1]}) * $signed(r_ca);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_t <= n_t;
        end
        if (w_en[1]) begin
            r_s1_t <= r_s0_t;
            r_s1_f <= n_sq[bsce_pkg::ACC_W-1:bsce_pkg::WORD_W];
        end
        if (w_en[2]) begin
            r_s2_t <= r_s1_t;
            r_s2_f <= n_cube[bsce_pkg::ACC_W-1:bsce_pkg::WORD_W];
        end
        if (w_en[3]) begin
            r_s3_t  <= r_s2_t;
            r_s3_f  <= n_quart[bsce_pkg::ACC_W-1:bsce_pkg::WORD_W];
            r_s3_pc <= $unsigned(n_pc);
        end
        if (w_en[4]) begin
            r_s4_f   <= n_quint[bsce_pkg::ACC_W-1:bsce_pkg::WORD_W];
            r_s4_pb  <= $unsigned(n_pb);
            r_s4_acc <= n_acc_init + r_s3_pc;
        end
        if (w_en[5]) begin
            r_s5_pa  <= $unsigned(n_pa);
            r_s5_acc <= r_s4_acc + r_s4_pb;
        end
        if (w_en[6]) begin
            r_s6_acc <= r_s5_acc + r_s5_pa;
        end
    end

    // output word: upper accumulator word, logical shift right by six
    assign o_rate.valid     = r_v[D-1];
    assign o_rate.step_rate = r_s6_acc[bsce_pkg::ACC_W-1:bsce_pkg::OUT_LSB];

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // an empty first stage always takes a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> i_step.ready)
        else $error("input not ready while first stage is empty");

    // an accepted word shows up in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.valid && i_step.ready) |=> r_v[0])
        else $error("accepted word lost at first stage");

    // a held first stage keeps its payload
    a_stage0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && !w_en[0]) |=> (r_v[0] && $stable(r_s0_t)))
        else $error("first stage changed while stalled");

    // with every stage full and the output blocked, input is refused
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_v) && !o_rate.ready) |-> !i_step.ready)
        else $error("input accepted while pipeline full and stalled");

    // a word moving out of stage five lands in the output stage
    a_last_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[D-2] && w_en[D-1]) |=> r_v[D-1])
        else $error("word lost entering output stage");

endmodule

FILE: dv/bsce_checker.sv
// bsce_checker: watches the configuration, step position and step rate channels,
// predicts every step rate word and compares it; depends on bsce_pkg
module bsce_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [bsce_pkg::ADDR_W-1:0] i_cfg_addr,
    input  logic [bsce_pkg::WORD_W-1:0] i_cfg_data,
    input  logic                        i_step_valid,
    input  logic                        i_step_ready,
    input  logic [bsce_pkg::WORD_W-1:0] i_step_position,
    input  logic                        i_rate_valid,
    input  logic                        i_rate_ready,
    input  logic [bsce_pkg::OUT_W-1:0]  i_step_rate,
    output int                          o_fail_count,
    output int                          o_outstanding
);

    logic [bsce_pkg::RATE_W-1:0] v_start;
    logic [bsce_pkg::RATE_W-1:0] v_end;
    logic [bsce_pkg::WORD_W-1:0] cfg_scale;
    logic [bsce_pkg::OUT_W-1:0]  rate_q[$];
    logic [bsce_pkg::OUT_W-1:0]  want_rate;
    int                          fails;

    function automatic logic [bsce_pkg::WORD_W-1:0] hi_prod(
        input logic [bsce_pkg::WORD_W-1:0] a,
        input logic [bsce_pkg::WORD_W-1:0] b);
        logic [bsce_pkg::ACC_W-1:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[bsce_pkg::ACC_W-1:bsce_pkg::WORD_W];
    endfunction

    // adds (f>>1) times a signed coefficient, wrapping at 64 bits
    function automatic logic [bsce_pkg::ACC_W-1:0] add_term(
        input logic [bsce_pkg::ACC_W-1:0]  acc,
        input logic [bsce_pkg::WORD_W-1:0] f,
        input logic [bsce_pkg::WORD_W-1:0] coef);
        logic signed [bsce_pkg::ACC_W-1:0] mag;
        logic signed [bsce_pkg::ACC_W-1:0] c;
        logic signed [bsce_pkg::ACC_W-1:0] prod;
        mag  = {33'd0, f[bsce_pkg::WORD_W-1:1]};
        c    = {{32{coef[bsce_pkg::WORD_W-1]}}, coef};
        prod = mag * c;
        return acc + prod;
    endfunction

    function automatic logic [bsce_pkg::OUT_W-1:0] curve_rate(
        input logic [bsce_pkg::RATE_W-1:0] v0,
        input logic [bsce_pkg::RATE_W-1:0] v1,
        input logic [bsce_pkg::WORD_W-1:0] scale,
        input logic [bsce_pkg::WORD_W-1:0] pos);
        logic [bsce_pkg::WORD_W-1:0] r0;
        logic [bsce_pkg::WORD_W-1:0] r1;
        logic [bsce_pkg::WORD_W-1:0] diff;
        logic [bsce_pkg::WORD_W-1:0] ca;
        logic [bsce_pkg::WORD_W-1:0] cb;
        logic [bsce_pkg::WORD_W-1:0] cc;
        logic [bsce_pkg::WORD_W-1:0] cf;
        logic [bsce_pkg::WORD_W-1:0] t;
        logic [bsce_pkg::WORD_W-1:0] f;
        logic [bsce_pkg::ACC_W-1:0]  acc;
        r0   = {12'd0, v0};
        r1   = {12'd0, v1};
        diff = r1 - r0;
        ca   = bsce_pkg::COEF_A * diff;
        cb   = bsce_pkg::COEF_B * (r0 - r1);
        cc   = bsce_pkg::COEF_C * diff;
        cf   = bsce_pkg::COEF_F * r0;
        t    = scale * pos;
        acc  = {32'd0, cf} << bsce_pkg::F_SHIFT;
        f    = hi_prod(t, t);
        f    = hi_prod(f, t);
        acc  = add_term(acc, f, cc);
        f    = hi_prod(f, t);
        acc  = add_term(acc, f, cb);
        f    = hi_prod(f, t);
        acc  = add_term(acc, f, ca);
        return acc[bsce_pkg::ACC_W-1:bsce_pkg::OUT_LSB];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            v_start   = '0;
            v_end     = '0;
            cfg_scale = '0;
            rate_q.delete();
            fails     = 0;
        end else begin
            if (i_step_valid && i_step_ready)
                rate_q.push_back(curve_rate(v_start, v_end, cfg_scale, i_step_position));
            if (i_rate_valid && i_rate_ready) begin
                if (rate_q.size() == 0) begin
                    $error("unexpected step_rate word %0h", i_step_rate);
                    fails++;
                end else begin
                    want_rate = rate_q.pop_front();
                    if (i_step_rate !== want_rate) begin
                        $error("step_rate mismatch: expected %0h actual %0h",
                               want_rate, i_step_rate);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    bsce_pkg::CFG_START_RATE: v_start   = i_cfg_data[bsce_pkg::RATE_W-1:0];
                    bsce_pkg::CFG_END_RATE:   v_end     = i_cfg_data[bsce_pkg::RATE_W-1:0];
                    bsce_pkg::CFG_TIME_SCALE: cfg_scale = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_outstanding <= rate_q.size();
        o_fail_count  <= fails;
    end

endmodule

FILE: dv/tb.sv
// tb: stimulus and verdict for bezier_speed_curve_eval, checked by bsce_checker
// depends on bsce_pkg, the channel interfaces and the block itself
module tb;

    // index with no register behind it, writes must be dropped
    localparam logic [bsce_pkg::ADDR_W-1:0] CFG_SPARE = 2'd3;
    localparam int IDLE_PCT     = 13;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 70;
    localparam int QUIET_PHASE  = 4;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   quiet;
    int   cycles = 0;
    int   fail_count;
    int   outstanding;

    bsce_cfg_if  cfg_ch ();
    bsce_step_if step_ch ();
    bsce_rate_if rate_ch ();

    bezier_speed_curve_eval dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_step  (step_ch),
        .o_rate  (rate_ch)
    );

    bsce_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_ch.valid),
        .i_cfg_ready     (cfg_ch.ready),
        .i_cfg_addr      (cfg_ch.addr),
        .i_cfg_data      (cfg_ch.data),
        .i_step_valid    (step_ch.valid),
        .i_step_ready    (step_ch.ready),
        .i_step_position (step_ch.step_position),
        .i_rate_valid    (rate_ch.valid),
        .i_rate_ready    (rate_ch.ready),
        .i_step_rate     (rate_ch.step_rate),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: covers a stuck handshake or a word that never comes back
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver side: random back-pressure, none during the quiet phase
    initial begin
        rate_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rate_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // one register write; valid is left high so writes can go back to back
    task automatic cfg_write(input logic [bsce_pkg::ADDR_W-1:0] idx,
                             input logic [bsce_pkg::WORD_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic set_curve(input logic [bsce_pkg::WORD_W-1:0] v0,
                             input logic [bsce_pkg::WORD_W-1:0] v1,
                             input logic [bsce_pkg::WORD_W-1:0] scale);
        cfg_write(bsce_pkg::CFG_START_RATE, v0);
        cfg_write(bsce_pkg::CFG_END_RATE, v1);
        cfg_write(bsce_pkg::CFG_TIME_SCALE, scale);
        cfg_ch.valid <= 1'b0;
    endtask

    // send one step position word, with a random gap in front of it
    task automatic push_step(input logic [bsce_pkg::WORD_W-1:0] pos);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            step_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        step_ch.valid         <= 1'b1;
        step_ch.step_position <= pos;
        do @(posedge i_clk); while (!step_ch.ready);
    endtask

    // hold off until every predicted rate word is back and the pipe is empty
    task automatic drain();
        step_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (bsce_pkg::PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // rate register word: extremes or random, junk above bit 19
    function automatic logic [bsce_pkg::WORD_W-1:0] rate_word();
        logic [bsce_pkg::WORD_W-1:0] junk;
        junk = $urandom() & 32'hFFF0_0000;
        case ($urandom_range(3))
            0:       return junk;
            1:       return junk | 32'h000F_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [bsce_pkg::WORD_W-1:0] scale_word();
        case ($urandom_range(4))
            0:       return 32'hFFFF_FFFF;
            1:       return $urandom_range(4096, 1);
            2:       return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [bsce_pkg::WORD_W-1:0] v0;
        logic [bsce_pkg::WORD_W-1:0] v1;
        logic [bsce_pkg::WORD_W-1:0] scale;
        logic [bsce_pkg::WORD_W-1:0] base;
        logic [bsce_pkg::WORD_W-1:0] pos;

        cfg_ch.valid          = 1'b0;
        cfg_ch.addr           = '0;
        cfg_ch.data           = '0;
        step_ch.valid         = 1'b0;
        step_ch.step_position = '0;
        i_rst_n               = 1'b0;
        quiet                 = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: all zero, so every rate is zero
        push_step(32'd0);
        push_step(32'hFFFF_FFFF);
        drain();

        // accelerate from rest at unit scale, t equals the step position
        set_curve(32'd0, 32'h000F_FFFF, 32'd1);
        push_step(32'd0);
        push_step(32'd1);
        push_step(32'h7FFF_FFFF);
        push_step(32'h8000_0000);
        push_step(32'hFFFF_FFFF);
        drain();

        // decelerate to rest, t wraps to the top of its range
        set_curve(32'h000F_FFFF, 32'd0, 32'hFFFF_FFFF);
        push_step(32'd1);
        push_step(32'hFFFF_FFFF);
        push_step(32'd0);
        push_step(32'h5555_5555);
        push_step(32'hAAAA_AAAA);
        drain();

        // junk above the rate width gets dropped, spare index is ignored
        cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
        cfg_write(bsce_pkg::CFG_START_RATE, 32'hFFFF_FFFF);
        cfg_write(bsce_pkg::CFG_END_RATE, 32'hFFF0_0000);
        cfg_write(bsce_pkg::CFG_TIME_SCALE, 32'h8000_0001);
        cfg_write(CFG_SPARE, 32'h0000_0000);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        push_step(32'd1);
        push_step(32'h0000_FFFF);
        push_step(32'hFFFF_0000);
        push_step(32'h1234_5678);
        drain();

        // flat curve at full rate: only the constant term is left
        set_curve(32'h000F_FFFF, 32'h000F_FFFF, 32'hFFFF_FFFF);
        push_step(32'd0);
        push_step(32'd2);
        push_step(32'hDEAD_BEEF);
        drain();

        // random phases, one of them with no idling on either side
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            quiet <= (ph == QUIET_PHASE);
            v0    = rate_word();
            v1    = rate_word();
            scale = scale_word();
            if ($urandom_range(2) == 0)
                cfg_write(CFG_SPARE, $urandom());
            set_curve(v0, v1, scale);
            base = $urandom();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(3))
                    0, 1: pos = $urandom();
                    // walk along the segment like a real move
                    2:    pos = base + k;
                    default: begin
                        case ($urandom_range(3))
                            0:       pos = 32'd0;
                            1:       pos = 32'hFFFF_FFFF;
                            2:       pos = 32'h8000_0000;
                            default: pos = $urandom_range(1000);
                        endcase
                    end
                endcase
                push_step(pos);
            end
            drain();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
